// ===== rtl/cbq_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbq_pkg
// shared types, coefficient, shift and gain tables of the complex biquad
// channel filter
// ---------------------------------------------------------------------------
package cbq_pkg;

    localparam int STAGES       = 4;
    localparam int SAMPLE_WIDTH = 16;
    localparam int ACC_WIDTH    = 32;
    localparam int FRAC_BITS    = 9;
    localparam int NUM_FILTERS  = 7;
    localparam int STAGE_W      = $clog2(STAGES);
    localparam int FSEL_W       = $clog2(NUM_FILTERS);
    localparam int COEF_W       = 12;
    localparam int GAIN_W       = 14;
    localparam int SHIFT_W      = 3;

    localparam logic [FSEL_W-1:0] NARROW_FILTER   = FSEL_W'(6);
    localparam logic [2:0]        NARROW_PRESHIFT = 3'd4;
    localparam logic [2:0]        NORMAL_PRESHIFT = 3'd3;

    typedef logic signed [COEF_W-1:0] t_coef;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample_re;
        logic signed [SAMPLE_WIDTH-1:0] sample_im;
        logic                           block_end;
    } t_in_beat;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] out_re;
        logic signed [SAMPLE_WIDTH-1:0] out_im;
        logic                           out_block_end;
    } t_out_beat;

    typedef struct packed {
        logic               load;
        logic               mul;
        logic               acc;
        logic [STAGE_W-1:0] st;
        logic [FSEL_W-1:0]  fsel;
    } t_lane_ctl;

    typedef struct packed {
        logic              mul;
        logic              push;
        logic [FSEL_W-1:0] fsel;
    } t_merge_ctl;

    localparam t_coef B1_TAB [NUM_FILTERS][STAGES] = '{
        '{ 12'sd211,  -12'sd634, -12'sd776, -12'sd809},
        '{ 12'sd296,  -12'sd571, -12'sd729, -12'sd766},
        '{ 12'sd778,   12'sd63,  -12'sd205, -12'sd283},
        '{ 12'sd849,   12'sd243, -12'sd36,  -12'sd124},
        '{ 12'sd1003,  12'sd896,  12'sd814,  12'sd782},
        '{ 12'sd1017,  12'sd977,  12'sd942,  12'sd926},
        '{-12'sd578,  -12'sd927, -12'sd958, -12'sd964}
    };

    // feedback coefficients stored negated
    localparam t_coef A1N_TAB [NUM_FILTERS][STAGES] = '{
        '{ 12'sd870,  12'sd856,  12'sd845,  12'sd844},
        '{ 12'sd850,  12'sd826,  12'sd809,  12'sd805},
        '{ 12'sd689,  12'sd540,  12'sd428,  12'sd387},
        '{ 12'sd653,  12'sd462,  12'sd318,  12'sd261},
        '{ 12'sd59,  -12'sd456, -12'sd654, -12'sd716},
        '{-12'sd168, -12'sd674, -12'sd830, -12'sd878},
        '{ 12'sd926,  12'sd948,  12'sd961,  12'sd967}
    };

    localparam t_coef A2N_TAB [NUM_FILTERS][STAGES] = '{
        '{-12'sd382, -12'sd434, -12'sd479, -12'sd503},
        '{-12'sd367, -12'sd427, -12'sd477, -12'sd503},
        '{-12'sd272, -12'sd376, -12'sd457, -12'sd498},
        '{-12'sd254, -12'sd364, -12'sd451, -12'sd496},
        '{-12'sd113, -12'sd367, -12'sd466, -12'sd501},
        '{-12'sd119, -12'sd389, -12'sd473, -12'sd502},
        '{-12'sd425, -12'sd471, -12'sd499, -12'sd509}
    };

    localparam logic [SHIFT_W-1:0] SHIFT_TAB [NUM_FILTERS][STAGES] = '{
        '{3'd5, 3'd2, 3'd2, 3'd1},
        '{3'd4, 3'd2, 3'd2, 3'd0},
        '{3'd3, 3'd2, 3'd1, 3'd0},
        '{3'd3, 3'd2, 3'd1, 3'd0},
        '{3'd1, 3'd0, 3'd1, 3'd0},
        '{3'd1, 3'd0, 3'd1, 3'd0},
        '{3'd4, 3'd2, 3'd2, 3'd0}
    };

    localparam logic [GAIN_W-1:0] GAIN_TAB [NUM_FILTERS] = '{
        14'd7696, 14'd2592, 14'd2184, 14'd2488, 14'd2408, 14'd4032, 14'd10976
    };

endpackage

// ===== rtl/cbq_lane.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbq_lane
// one real-valued lane: four direct-form-II biquad sections run on a shared
// datapath, one section at a time (products, then sums)
// ---------------------------------------------------------------------------
module cbq_lane (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  cbq_pkg::t_lane_ctl                     i_ctl,
    input  logic signed [cbq_pkg::SAMPLE_WIDTH-1:0] i_sample,
    output logic signed [cbq_pkg::SAMPLE_WIDTH-1:0] o_x
);

    localparam int AW = cbq_pkg::ACC_WIDTH;
    localparam int PW = cbq_pkg::ACC_WIDTH + cbq_pkg::COEF_W;

    logic signed [AW-1:0] r_d1 [cbq_pkg::STAGES];
    logic signed [AW-1:0] r_d2 [cbq_pkg::STAGES];
    logic signed [AW-1:0] r_pa1, r_pa2, r_pb;
    logic signed [cbq_pkg::SAMPLE_WIDTH-1:0] r_x;

    logic signed [AW-1:0] w1, w2, sum_a, w0, y, y_sh;
    logic signed [PW-1:0] p_a1, p_a2, p_b;
    logic [2:0]           pre;
    logic signed [cbq_pkg::SAMPLE_WIDTH-1:0] x_in;

    assign w1 = r_d1[i_ctl.st];
    assign w2 = r_d2[i_ctl.st];

    assign p_a1 = w1 * cbq_pkg::A1N_TAB[i_ctl.fsel][i_ctl.st];
    assign p_a2 = w2 * cbq_pkg::A2N_TAB[i_ctl.fsel][i_ctl.st];
    assign p_b  = w1 * cbq_pkg::B1_TAB[i_ctl.fsel][i_ctl.st];

    assign sum_a = r_pa1 + r_pa2;
    assign w0    = (sum_a >>> cbq_pkg::FRAC_BITS) + AW'(r_x);
    assign y     = w0 + (r_pb >>> cbq_pkg::FRAC_BITS) + w2;
    assign y_sh  = y >>> cbq_pkg::SHIFT_TAB[i_ctl.fsel][i_ctl.st];

    assign pre  = (i_ctl.fsel == cbq_pkg::NARROW_FILTER) ? cbq_pkg::NARROW_PRESHIFT
                                                         : cbq_pkg::NORMAL_PRESHIFT;
    assign x_in = i_sample >>> pre;

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            r_pa1 <= p_a1[AW-1:0];
            r_pa2 <= p_a2[AW-1:0];
            r_pb  <= p_b[AW-1:0];
        end
        if (i_ctl.load) begin
            r_x <= x_in;
        end else if (i_ctl.acc) begin
            r_x <= y_sh[cbq_pkg::SAMPLE_WIDTH-1:0];
        end
    end

    // delay line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < cbq_pkg::STAGES; i++) begin
                r_d1[i] <= '0;
                r_d2[i] <= '0;
            end
        end else if (i_ctl.acc) begin
            r_d1[i_ctl.st] <= w0;
            r_d2[i_ctl.st] <= w1;
        end
    end

    assign o_x = r_x;

endmodule

// ===== rtl/cbq_merge.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbq_merge
// applies the output gain to both lanes and holds the result beat in the
// output register
// ---------------------------------------------------------------------------
module cbq_merge (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  cbq_pkg::t_merge_ctl                    i_ctl,
    input  logic signed [cbq_pkg::SAMPLE_WIDTH-1:0] i_x_re,
    input  logic signed [cbq_pkg::SAMPLE_WIDTH-1:0] i_x_im,
    input  logic                                   i_block_end,
    input  logic                                   i_out_stall,
    output logic                                   o_free,
    output logic                                   o_out_valid,
    output cbq_pkg::t_out_beat                     o_out_beat
);

    localparam int GPW = cbq_pkg::SAMPLE_WIDTH + cbq_pkg::GAIN_W + 1;
    localparam int LSB = cbq_pkg::FRAC_BITS;
    localparam int MSB = cbq_pkg::FRAC_BITS + cbq_pkg::SAMPLE_WIDTH - 1;

    logic signed [GPW-1:0] r_pr, r_pi;
    logic                  r_valid;
    cbq_pkg::t_out_beat    r_beat;
    logic signed [cbq_pkg::GAIN_W:0] gain;

    assign gain   = $signed({1'b0, cbq_pkg::GAIN_TAB[i_ctl.fsel]});
    assign o_free = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            r_pr <= i_x_re * gain;
            r_pi <= i_x_im * gain;
        end
        if (i_ctl.push) begin
            r_beat.out_re        <= r_pr[MSB:LSB];
            r_beat.out_im        <= r_pi[MSB:LSB];
            r_beat.out_block_end <= i_block_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.push) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_beat  = r_beat;

endmodule

// ===== rtl/complex_biquad_channel_filter_core.sv =====
`timescale 1ns / 1ps
// one input beat at a time: the input side stalls until the result is pushed;
// each of the four sections takes a multiply state and a sum state on the
// shared multiply/sum datapath of each lane, then gain and push
// the result register frees the input side, so output stall costs nothing
// until a second result is ready
// reset (synchronous, active low) clears delay lines, filter select and valids
// ---------------------------------------------------------------------------
// complex_biquad_channel_filter_core
// complex I/Q four-section biquad channel filter, real and imaginary lanes
// side by side with a shared gain and output stage
// ---------------------------------------------------------------------------
module complex_biquad_channel_filter_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  cbq_pkg::t_in_beat                i_in_beat,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output cbq_pkg::t_out_beat               o_out_beat,
    input  logic                             i_cfg_we,
    input  logic [cbq_pkg::FSEL_W-1:0]       i_cfg_wdata
);

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_ACC, S_GAIN, S_PUSH} t_state;

    t_state                      r_state;
    logic [cbq_pkg::STAGE_W-1:0] r_st;
    logic [cbq_pkg::FSEL_W-1:0]  r_fsel;
    logic                        r_be;
    logic                        accept, free;
    cbq_pkg::t_lane_ctl          lane_ctl;
    cbq_pkg::t_merge_ctl         merge_ctl;
    logic signed [cbq_pkg::SAMPLE_WIDTH-1:0] x_re, x_im;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        lane_ctl.load  = accept;
        lane_ctl.mul   = (r_state == S_MUL);
        lane_ctl.acc   = (r_state == S_ACC);
        lane_ctl.st    = r_st;
        lane_ctl.fsel  = r_fsel;
        merge_ctl.mul  = (r_state == S_GAIN);
        merge_ctl.push = (r_state == S_PUSH) && free;
        merge_ctl.fsel = r_fsel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsel <= '0;
        end else if (i_cfg_we && (i_cfg_wdata < cbq_pkg::FSEL_W'(cbq_pkg::NUM_FILTERS))) begin
            r_fsel <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_st    <= '0;
            r_be    <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_MUL;
                        r_st    <= '0;
                        r_be    <= i_in_beat.block_end;
                    end
                end
                S_MUL: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (r_st == cbq_pkg::STAGE_W'(cbq_pkg::STAGES - 1)) begin
                        r_state <= S_GAIN;
                    end else begin
                        r_st    <= r_st + 1'b1;
                        r_state <= S_MUL;
                    end
                end
                S_GAIN: begin
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    if (free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    cbq_lane u_lane_re (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (lane_ctl),
        .i_sample (i_in_beat.sample_re),
        .o_x      (x_re)
    );

    cbq_lane u_lane_im (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (lane_ctl),
        .i_sample (i_in_beat.sample_im),
        .o_x      (x_im)
    );

    cbq_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (merge_ctl),
        .i_x_re      (x_re),
        .i_x_im      (x_im),
        .i_block_end (r_be),
        .i_out_stall (i_out_stall),
        .o_free      (free),
        .o_out_valid (o_out_valid),
        .o_out_beat  (o_out_beat)
    );

endmodule

// ===== rtl/cbq_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbq_checker
// port-level checks of the channel filter core, attached by bind
// ---------------------------------------------------------------------------
module cbq_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_stall,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input cbq_pkg::t_out_beat         o_out_beat
);

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_beat))
        else $error("output beat dropped or changed under stall");

    // block is busy right after an accepted beat
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again right after accept");

    // still busy while the sections run
    a_busy_through_sections: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> ##8 o_in_stall)
        else $error("input side freed before the sections finished");

    // a new result only appears at the end of a busy period
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without work in flight");

endmodule

bind complex_biquad_channel_filter_core cbq_checker u_cbq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_beat  (o_out_beat)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// self-checking bench for complex_biquad_channel_filter_core: I/Q beats are
// driven from a queue with random gaps, output stall is random, and every
// output beat is checked against a bit-exact four-section biquad predictor
// that follows each filter select write
// ---------------------------------------------------------------------------
module tb;

    localparam int N_SEL      = 7;
    localparam int NARROW_SEL = 6;
    localparam int Q_BITS     = 9;
    localparam int N_SEC      = 4;
    localparam int IDLE_PCT   = 29;
    localparam int RST_CYCLES = 11;

    // b1, a1, a2 per section, Q9
    localparam int B1_Q9 [N_SEL][N_SEC] = '{
        '{ 211, -634, -776, -809},
        '{ 296, -571, -729, -766},
        '{ 778,   63, -205, -283},
        '{ 849,  243,  -36, -124},
        '{1003,  896,  814,  782},
        '{1017,  977,  942,  926},
        '{-578, -927, -958, -964}
    };
    localparam int A1_Q9 [N_SEL][N_SEC] = '{
        '{-870, -856, -845, -844},
        '{-850, -826, -809, -805},
        '{-689, -540, -428, -387},
        '{-653, -462, -318, -261},
        '{ -59,  456,  654,  716},
        '{ 168,  674,  830,  878},
        '{-926, -948, -961, -967}
    };
    localparam int A2_Q9 [N_SEL][N_SEC] = '{
        '{382, 434, 479, 503},
        '{367, 427, 477, 503},
        '{272, 376, 457, 498},
        '{254, 364, 451, 496},
        '{113, 367, 466, 501},
        '{119, 389, 473, 502},
        '{425, 471, 499, 509}
    };
    localparam int SEC_SHIFT [N_SEL][N_SEC] = '{
        '{5, 2, 2, 1}, '{4, 2, 2, 0}, '{3, 2, 1, 0}, '{3, 2, 1, 0},
        '{1, 0, 1, 0}, '{1, 0, 1, 0}, '{4, 2, 2, 0}
    };
    localparam int OUT_GAIN [N_SEL] = '{7696, 2592, 2184, 2488, 2408, 4032, 10976};

    typedef enum logic [1:0] {
        STEP_BEAT,
        STEP_FSEL,
        STEP_SYNC
    } t_step_kind;

    typedef struct {
        t_step_kind           kind;
        cbq_pkg::t_in_beat    beat;
        logic [2:0]           fsel;
    } t_stim_step;

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_in_valid  = 1'b0;
    logic                            o_in_stall;
    cbq_pkg::t_in_beat               i_in_beat   = '0;
    logic                            o_out_valid;
    logic                            i_out_stall = 1'b0;
    cbq_pkg::t_out_beat              o_out_beat;
    logic                            i_cfg_we    = 1'b0;
    logic [cbq_pkg::FSEL_W-1:0]      i_cfg_wdata = '0;

    t_stim_step          stim_plan [$];
    cbq_pkg::t_out_beat  predicted_out [$];

    logic [2:0]   model_fsel = '0;
    logic [31:0]  z1 [2][N_SEC];
    logic [31:0]  z2 [2][N_SEC];

    int   n_err     = 0;
    int   n_in      = 0;
    int   n_out     = 0;
    int   n_fsel_wr = 0;
    int   rst_count = 0;
    logic [7:0] fsel_seen = '0;
    logic beat_taken = 1'b0;
    logic calm;

    complex_biquad_channel_filter_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("tb NOT OK");
        $finish;
    end

    function automatic logic [31:0] asr32(input logic [31:0] v, input int s);
        return 32'($signed(v) >>> s);
    endfunction

    function automatic logic [31:0] sext16(input logic [31:0] v);
        return {{16{v[15]}}, v[15:0]};
    endfunction

    function automatic logic [31:0] run_section(input int lane, input int st, input int fs,
                                                input logic [31:0] x);
        logic [31:0] w1, w2, w0, fb, y;
        w1 = z1[lane][st];
        w2 = z2[lane][st];
        fb = w1 * 32'(-A1_Q9[fs][st]) + w2 * 32'(-A2_Q9[fs][st]);
        w0 = asr32(fb, Q_BITS) + x;
        y  = w0 + asr32(w1 * 32'(B1_Q9[fs][st]), Q_BITS) + w2;
        z2[lane][st] = w1;
        z1[lane][st] = w0;
        return sext16(asr32(y, SEC_SHIFT[fs][st]));
    endfunction

    function automatic cbq_pkg::t_out_beat filter_beat(input cbq_pkg::t_in_beat b);
        cbq_pkg::t_out_beat r;
        logic [31:0] xr, xi, g, pr, pi;
        int fs, pre;
        fs  = int'(model_fsel);
        pre = (fs == NARROW_SEL) ? 4 : 3;
        xr  = asr32(sext16({16'd0, b.sample_re}), pre);
        xi  = asr32(sext16({16'd0, b.sample_im}), pre);
        for (int st = 0; st < N_SEC; st++) begin
            xr = run_section(0, st, fs, xr);
            xi = run_section(1, st, fs, xi);
        end
        g  = 32'(OUT_GAIN[fs]);
        pr = asr32(xr * g, Q_BITS);
        pi = asr32(xi * g, Q_BITS);
        r.out_re        = pr[15:0];
        r.out_im        = pi[15:0];
        r.out_block_end = b.block_end;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        n_err++;
        $display("ERROR at %0t: %s", $time, msg);
    endtask

    task automatic add_beat(input logic [15:0] re, input logic [15:0] im, input logic be);
        t_stim_step s;
        s.kind           = STEP_BEAT;
        s.beat.sample_re = re;
        s.beat.sample_im = im;
        s.beat.block_end = be;
        s.fsel           = '0;
        stim_plan.push_back(s);
    endtask

    task automatic add_fsel(input logic [2:0] v);
        t_stim_step s;
        s.kind = STEP_FSEL;
        s.beat = '0;
        s.fsel = v;
        stim_plan.push_back(s);
    endtask

    task automatic add_sync();
        t_stim_step s;
        s.kind = STEP_SYNC;
        s.beat = '0;
        s.fsel = '0;
        stim_plan.push_back(s);
    endtask

    function automatic logic [15:0] pick_sample();
        int m;
        m = $urandom_range(0, 99);
        if (m < 40)
            return 16'($urandom);
        else if (m < 70)
            return 16'($urandom_range(0, 4095) - 2048);
        else if (m < 85)
            return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
        else
            return 16'($urandom_range(0, 255));
    endfunction

    assign calm = (n_in >= 400) && (n_in < 600);

    function automatic logic roll_idle();
        return !calm && ($urandom_range(0, 99) < IDLE_PCT);
    endfunction

    // reset release, input beats, filter select writes and output stall
    always @(negedge i_clk) begin
        logic              nv;
        cbq_pkg::t_in_beat nb;
        logic              nwe;
        logic [2:0]        nwd;
        nv  = i_in_valid;
        nb  = i_in_beat;
        nwe = 1'b0;
        nwd = i_cfg_wdata;
        if (rst_count < RST_CYCLES) begin
            rst_count++;
            if (rst_count == RST_CYCLES)
                i_rst_n <= 1'b1;
        end else if (i_rst_n) begin
            if (nv && beat_taken)
                nv = 1'b0;
            beat_taken = 1'b0;
            if (!nv && stim_plan.size() > 0) begin
                case (stim_plan[0].kind)
                    STEP_BEAT: begin
                        if (!roll_idle()) begin
                            nv = 1'b1;
                            nb = stim_plan[0].beat;
                            void'(stim_plan.pop_front());
                        end
                    end
                    STEP_FSEL: begin
                        if (predicted_out.size() == 0) begin
                            nwe = 1'b1;
                            nwd = stim_plan[0].fsel;
                            void'(stim_plan.pop_front());
                        end
                    end
                    default: begin
                        if (predicted_out.size() == 0)
                            void'(stim_plan.pop_front());
                    end
                endcase
            end
            i_out_stall <= roll_idle();
        end
        i_in_valid  <= nv;
        i_in_beat   <= nb;
        i_cfg_we    <= nwe;
        i_cfg_wdata <= nwd;
    end

    // output check, then register writes and accepted input beats
    always @(posedge i_clk) begin
        cbq_pkg::t_out_beat want;
        if (!i_rst_n) begin
            model_fsel = '0;
            for (int l = 0; l < 2; l++) begin
                for (int st = 0; st < N_SEC; st++) begin
                    z1[l][st] = '0;
                    z2[l][st] = '0;
                end
            end
        end else begin
            if (o_out_valid && !i_out_stall) begin
                n_out++;
                if (predicted_out.size() == 0) begin
                    report_mismatch($sformatf("unexpected output beat re=%h im=%h end=%b",
                        o_out_beat.out_re, o_out_beat.out_im, o_out_beat.out_block_end));
                end else begin
                    want = predicted_out.pop_front();
                    if (o_out_beat.out_re !== want.out_re)
                        report_mismatch($sformatf("out %0d: out_re %h, want %h",
                            n_out, o_out_beat.out_re, want.out_re));
                    if (o_out_beat.out_im !== want.out_im)
                        report_mismatch($sformatf("out %0d: out_im %h, want %h",
                            n_out, o_out_beat.out_im, want.out_im));
                    if (o_out_beat.out_block_end !== want.out_block_end)
                        report_mismatch($sformatf("out %0d: out_block_end %b, want %b",
                            n_out, o_out_beat.out_block_end, want.out_block_end));
                end
            end
            if (i_cfg_we) begin
                n_fsel_wr++;
                if (int'(i_cfg_wdata) < N_SEL)
                    model_fsel = i_cfg_wdata;
            end
            if (i_in_valid && !o_in_stall) begin
                predicted_out.push_back(filter_beat(i_in_beat));
                fsel_seen[model_fsel] = 1'b1;
                beat_taken = 1'b1;
                n_in++;
            end
        end
    end

    initial begin
        int   plen;
        logic [2:0] fs;

        // default filter after reset, full-scale and sign extremes
        add_beat(16'h7fff, 16'h7fff, 1'b1);
        add_beat(16'h8000, 16'h8000, 1'b0);
        add_beat(16'h0000, 16'h0000, 1'b0);
        add_beat(16'h7fff, 16'h8000, 1'b1);
        add_beat(16'h0001, 16'hffff, 1'b0);
        // narrow filter with its larger pre-shift, driven hard
        add_fsel(3'd6);
        repeat (3) add_beat(16'h8000, 16'h7fff, 1'b0);
        add_beat(16'h0000, 16'h0000, 1'b1);
        add_beat(16'hffff, 16'h0001, 1'b0);
        // out-of-range select must leave the narrow filter in place
        add_fsel(3'd7);
        repeat (2) add_beat(16'h7fff, 16'h7fff, 1'b0);
        // wide filters, state carried over, pushed into wraparound
        add_fsel(3'd4);
        repeat (3) add_beat(16'h7fff, 16'h8000, 1'b0);
        add_beat(16'h5555, 16'haaaa, 1'b1);
        add_fsel(3'd5);
        repeat (2) begin
            add_beat(16'h7fff, 16'h8000, 1'b0);
            add_beat(16'h8000, 16'h7fff, 1'b0);
        end

        for (int p = 0; p < 16; p++) begin
            fs = (p < 8) ? 3'(p) : 3'($urandom_range(0, 7));
            add_fsel(fs);
            plen = $urandom_range(50, 74);
            for (int k = 0; k < plen; k++) begin
                if (k == plen / 2 && $urandom_range(0, 2) == 0)
                    add_sync();
                add_beat(pick_sample(), pick_sample(),
                    (k == plen - 1) || ($urandom_range(0, 7) == 0));
            end
        end
        add_fsel(3'd0);
        repeat (8) add_beat(pick_sample(), pick_sample(), 1'b0);

        do begin
            @(posedge i_clk);
            #1;
        end while (stim_plan.size() != 0 || i_in_valid || predicted_out.size() != 0);
        repeat (40) @(posedge i_clk);
        #1;

        $display("run: %0d input beats, %0d output beats checked, %0d select writes",
            n_in, n_out, n_fsel_wr);
        $display("filters that saw traffic (bit per select): %b", fsel_seen[6:0]);
        if (n_err == 0 && predicted_out.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
